// ===== hdl/dffc_pkg.sv =====
// Package for the double / fixed-point format converter.
// Holds the operation and status codes, field constants and the word structs.
// No dependencies.
package dffc_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned ExpW    = 11;
  localparam int unsigned ManW    = 52;
  localparam int unsigned MagW    = 63;
  localparam int unsigned ShiftW  = 6;
  localparam int unsigned SignBit = 63;
  localparam int unsigned AlignW  = MagW - ManW - 1;  // pad below the mantissa

  // Biased exponent window that fits the fixed word: unbiased -61 .. +1.
  localparam logic [ExpW-1:0] ExpLow  = 11'd962;
  localparam logic [ExpW-1:0] ExpHigh = 11'd1024;

  typedef enum logic {
    OP_DBL2FIX = 1'b0,
    OP_FIX2DBL = 1'b1
  } dffc_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SUBNORMAL = 2'd1,
    ST_RANGE     = 2'd2
  } dffc_status_e;

  typedef struct packed {
    dffc_op_e          op;
    logic [WordW-1:0]  operand;
  } dffc_req_t;

  typedef struct packed {
    logic [WordW-1:0]  result;
    dffc_status_e      status;
  } dffc_rsp_t;

endpackage

// ===== hdl/dffc_req_if.sv =====
// Request channel of the format converter: operation code and operand word.
// Valid/ready handshake; no dependencies.
interface dffc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] operand;

  modport source (output valid, output operation, output operand, input ready);
  modport sink   (input valid, input operation, input operand, output ready);
endinterface

// ===== hdl/dffc_rsp_if.sv =====
// Response channel of the format converter: converted word and status code.
// Valid/ready handshake; no dependencies.
interface dffc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic [1:0]  status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

// ===== hdl/double_fixed_format_converter_core.sv =====
// Top level of the double / fixed-point format converter: input register,
// conversion datapath, result register. Depends on dffc_pkg, dffc_conv and the
// dffc_req_if / dffc_rsp_if interfaces.
//
//   channel  modport  direction  word carried
//   req_i    sink     in         operation (1), operand (64)
//   rsp_o    source   out        result (64), status (2)
//
// Registers: a word passes through the input register and then the result
// register; the datapath between them (a six-step leading zero normaliser and
// a 63-bit barrel shifter) sets the clock period.
// Throughput: one word per cycle, sustained while the sink keeps ready high.
// Stalls: a low ready on rsp_o holds the result register; the input register
// keeps accepting until it too is full, so req_i.ready falls only then.
// Reset: rst_ni clears both valid flags; payload registers are not reset.
module double_fixed_format_converter_core import dffc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dffc_req_if.sink   req_i,
  dffc_rsp_if.source rsp_o
);

  logic      in_valid_q, in_valid_d;
  dffc_req_t in_q;
  logic      rsp_valid_q, rsp_valid_d;
  dffc_rsp_t rsp_q;
  dffc_rsp_t conv_rsp;
  logic      out_free;
  logic      in_adv;
  logic      req_fire;

  // Result register can take a word when empty or being drained this cycle.
  assign out_free = !rsp_valid_q || rsp_o.ready;
  // Input register can take a word when empty or moving on this cycle.
  assign in_adv   = !in_valid_q || out_free;
  assign req_fire = req_i.valid && in_adv;

  assign req_i.ready = in_adv;

  assign in_valid_d  = in_adv   ? req_i.valid : in_valid_q;
  assign rsp_valid_d = out_free ? in_valid_q  : rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload: load on a handshake, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.op      <= dffc_op_e'(req_i.operation);
      in_q.operand <= req_i.operand;
    end
    if (out_free && in_valid_q) begin
      rsp_q <= conv_rsp;
    end
  end

  dffc_conv u_conv (
    .req_i (in_q),
    .rsp_o (conv_rsp)
  );

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.result = rsp_q.result;
  assign rsp_o.status = rsp_q.status;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.status != ST_OK) |-> (rsp_q.result == '0))
    else $error("error status with nonzero result");

  a_req_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> in_valid_q)
    else $error("accepted word missing from input register");

  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_free) |=> rsp_valid_q)
    else $error("word lost between input and result register");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled input register changed");
`endif

endmodule

// ===== hdl/dffc_norm.sv =====
// Leading-zero normaliser: counts leading zeros and shifts the word left.
// Six halving steps, 32 down to 1. Depends on dffc_pkg.
module dffc_norm import dffc_pkg::*; (
  input  logic [WordW-1:0]  word_i,
  output logic [ShiftW-1:0] lz_o,
  output logic [WordW-1:0]  norm_o
);

  logic [WordW-1:0]  stg [0:ShiftW];
  logic [ShiftW-1:0] lz;

  assign stg[0] = word_i;

  for (genvar g = 0; g < ShiftW; g++) begin : g_step
    localparam int unsigned Sh = (WordW / 2) >> g;
    assign lz[ShiftW-1-g] = (stg[g][WordW-1 -: Sh] == '0);
    assign stg[g+1]       = lz[ShiftW-1-g] ? (stg[g] << Sh) : stg[g];
  end

  assign lz_o   = lz;
  assign norm_o = stg[ShiftW];

endmodule

// ===== hdl/dffc_conv.sv =====
// Conversion datapath: double to fixed by a right barrel shift, fixed to double
// by leading-zero normalisation. Depends on dffc_pkg and dffc_norm.
module dffc_conv import dffc_pkg::*; (
  input  dffc_req_t req_i,
  output dffc_rsp_t rsp_o
);

  logic              sign;
  logic [ExpW-1:0]   biased;
  logic [ManW-1:0]   man;
  logic [ShiftW-1:0] rshift;
  logic [MagW-1:0]   aligned;
  logic [MagW-1:0]   mag;
  logic [ShiftW-1:0] lz;
  logic [WordW-1:0]  norm;
  logic [ExpW-1:0]   f2d_exp;

  assign sign   = req_i.operand[SignBit];
  assign biased = req_i.operand[SignBit-1 -: ExpW];
  assign man    = req_i.operand[ManW-1:0];
  assign mag    = req_i.operand[MagW-1:0];

  // Hidden bit sits at the top of the magnitude for exponent +1.
  assign rshift  = ShiftW'(ExpHigh - biased);
  assign aligned = {1'b1, man, {AlignW{1'b0}}} >> rshift;

  dffc_norm u_norm (
    .word_i ({mag, 1'b0}),
    .lz_o   (lz),
    .norm_o (norm)
  );

  assign f2d_exp = ExpHigh - ExpW'(lz);

  always_comb begin
    rsp_o.result = '0;
    rsp_o.status = ST_OK;
    case (req_i.op)
      OP_DBL2FIX: begin
        if (biased == '0) begin
          if (man != '0) rsp_o.status = ST_SUBNORMAL;
        end else if (biased < ExpLow || biased > ExpHigh) begin
          rsp_o.status = ST_RANGE;
        end else begin
          rsp_o.result = {sign, aligned};
        end
      end
      OP_FIX2DBL: begin
        // zero magnitude drops the sign and returns +0
        if (mag != '0) begin
          rsp_o.result = {sign, f2d_exp, norm[WordW-2 -: ManW]};
        end
      end
      default: begin
        rsp_o.result = '0;
        rsp_o.status = ST_OK;
      end
    endcase
  end

endmodule
